[hdl/aiod_pkg.sv]
// ----------------------------------------------------------------------------
// aiod_pkg
// Shared types, address map and helpers for the arcade I/O address decoder.
// ----------------------------------------------------------------------------
package aiod_pkg;

  // widths
  localparam int unsigned ADDR_W     = 15;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 2;

  // default number of sprite coordinate registers
  localparam int unsigned SPRITE_REG_COUNT_DEF = 16;

  // address map, after mirroring to 15 bits
  localparam logic [ADDR_W-1:0] CTRL_BASE     = 15'h5000;
  localparam logic [ADDR_W-1:0] PORT1_ADDR    = 15'h5040;
  localparam logic [ADDR_W-1:0] DIP_ADDR      = 15'h5080;
  localparam logic [ADDR_W-1:0] SPRITE_BASE   = 15'h5060;
  localparam logic [ADDR_W-1:0] WDOG_LO       = 15'h50C0;
  localparam logic [ADDR_W-1:0] WDOG_HI       = 15'h50FF;
  localparam logic [ADDR_W-1:0] SOUND_LO      = 15'h5040;
  localparam logic [ADDR_W-1:0] SOUND_HI      = 15'h505F;
  localparam logic [ADDR_W-1:0] LATCH_HI      = 15'h5007;
  localparam logic [ADDR_W-1:0] IRQ_EN_ADDR   = 15'h5000;
  localparam logic [ADDR_W-1:0] SOUND_EN_ADDR = 15'h5001;
  localparam logic [ADDR_W-1:0] FLIP_ADDR     = 15'h5003;

  // io port that loads the interrupt vector
  localparam logic [7:0] IO_VECTOR_PORT = 8'h00;

  // input port bit clears
  localparam logic [DATA_W-1:0] RACK_CLR_MASK = 8'b11101111;
  localparam logic [DATA_W-1:0] KEY_CLR_MASK  = 8'b11011111;

  // bus request kinds
  typedef enum logic [1:0] {
    REQ_MEM_RD = 2'd0,
    REQ_MEM_WR = 2'd1,
    REQ_IO_RD  = 2'd2,
    REQ_IO_WR  = 2'd3
  } req_type_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COIN  = 3'd0,
    CFG_LIVES = 3'd1,
    CFG_BONUS = 3'd2,
    CFG_DIFF  = 3'd3,
    CFG_GHOST = 3'd4,
    CFG_RACK  = 3'd5
  } cfg_idx_t;

  // one bus access
  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
    logic [3:0]  joystick;
    logic        coin_pressed;
    logic        start_pressed;
  } in_t;

  // one decode result
  typedef struct packed {
    logic [7:0]        read_byte;
    logic              to_memory;
    logic [ADDR_W-1:0] memory_address;
    logic              accepted;
    logic              irq_enable;
    logic              sound_enable;
    logic              screen_flip;
    logic [7:0]        irq_vector;
  } out_t;

  // dip switch settings
  typedef struct packed {
    logic [1:0] coin_mode;
    logic [1:0] lives_mode;
    logic [1:0] bonus_mode;
    logic       difficulty_mode;
    logic       ghost_name_mode;
    logic       rack_advance_off;
  } cfg_t;

  // sprite register file access
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [DATA_W-1:0] wr_data;
  } spr_ctl_t;

  // decoded access between input stage and result stage
  typedef struct packed {
    logic              use_sprite;
    logic [DATA_W-1:0] rd_byte;
    logic              to_memory;
    logic [ADDR_W-1:0] mem_addr;
    logic              accepted;
  } stage_t;

  // control latches
  typedef struct packed {
    logic              irq_enable;
    logic              sound_enable;
    logic              screen_flip;
    logic [DATA_W-1:0] irq_vector;
  } latch_t;

  // active-low input port byte
  function automatic logic [DATA_W-1:0] port_byte(input logic [3:0] joy,
                                                  input logic       key,
                                                  input logic       rack_clr);
    logic [DATA_W-1:0] v;
    v = ~{4'b0000, joy};
    if (key) begin
      v = v & KEY_CLR_MASK;
    end
    if (rack_clr) begin
      v = v & RACK_CLR_MASK;
    end
    return v;
  endfunction

endpackage

[hdl/aiod_sprite_mem.sv]
// ----------------------------------------------------------------------------
// aiod_sprite_mem
// Sprite coordinate register file with per-entry valid bits; an entry never
// written since reset reads as zero. Read data is registered.
// ----------------------------------------------------------------------------
module aiod_sprite_mem
  import aiod_pkg::*;
#(
  parameter int unsigned SPRITE_REG_COUNT = SPRITE_REG_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spr_ctl_t                            ctl,
  input  logic [$clog2(SPRITE_REG_COUNT)-1:0] idx,
  output logic [DATA_W-1:0]                   rd_data
);

  logic [DATA_W-1:0]           mem [SPRITE_REG_COUNT];
  logic [SPRITE_REG_COUNT-1:0] valid_r;
  logic [DATA_W-1:0]           rd_data_r;
  logic                        rd_valid_r;

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[idx] <= ctl.wr_data;
    end
  end

  // valid bits, cleared together at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[idx] <= 1'b1;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r  <= mem[idx];
      rd_valid_r <= valid_r[idx];
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : {DATA_W{1'b0}};

endmodule

[hdl/aiod_decode.sv]
// ----------------------------------------------------------------------------
// aiod_decode
// Input stage: mirrors and decodes one bus access, updates the control
// latches, drives the sprite register file and registers the decoded result.
// ----------------------------------------------------------------------------
module aiod_decode
  import aiod_pkg::*;
#(
  parameter int unsigned SPRITE_REG_COUNT = SPRITE_REG_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  in_t                                 in_data,
  input  cfg_t                                cfg,
  output spr_ctl_t                            spr_ctl,
  output logic [$clog2(SPRITE_REG_COUNT)-1:0] spr_idx,
  output stage_t                              stage_r,
  output logic                                stage_valid_r,
  output latch_t                              latch_r
);

  localparam int unsigned IDX_W = $clog2(SPRITE_REG_COUNT);
  localparam logic [ADDR_W-1:0] SPRITE_LAST = SPRITE_BASE + ADDR_W'(SPRITE_REG_COUNT - 1);

  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] spr_off;
  logic              in_spr;
  logic              in_wdog;
  logic              in_sound;
  req_type_t         req;
  stage_t            stage_nxt;
  latch_t            latch_nxt;

  // address mirroring and window compares
  assign addr     = in_data.bus_address[ADDR_W-1:0];
  assign spr_off  = addr - SPRITE_BASE;
  assign spr_idx  = spr_off[IDX_W-1:0];
  assign in_spr   = (addr >= SPRITE_BASE) && (addr <= SPRITE_LAST);
  assign in_wdog  = (addr >= WDOG_LO) && (addr <= WDOG_HI);
  assign in_sound = (addr >= SOUND_LO) && (addr <= SOUND_HI);
  assign req      = req_type_t'(in_data.req_type);

  // access decode
  always_comb begin
    stage_nxt            = '0;
    stage_nxt.accepted   = 1'b1;
    latch_nxt            = latch_r;
    spr_ctl              = '0;
    spr_ctl.wr_data      = in_data.write_byte;
    unique case (req)
      REQ_MEM_RD: begin
        priority if (addr == CTRL_BASE) begin
          stage_nxt.rd_byte = port_byte(in_data.joystick, in_data.coin_pressed,
                                        ~cfg.rack_advance_off);
        end else if (addr == PORT1_ADDR) begin
          stage_nxt.rd_byte = port_byte(in_data.joystick, in_data.start_pressed, 1'b0);
        end else if (addr == DIP_ADDR) begin
          stage_nxt.rd_byte = {cfg.ghost_name_mode, cfg.difficulty_mode,
                               cfg.bonus_mode, cfg.lives_mode, cfg.coin_mode};
        end else if (in_spr) begin
          stage_nxt.use_sprite = 1'b1;
          spr_ctl.rd_en        = in_valid;
        end else begin
          stage_nxt.to_memory = 1'b1;
          stage_nxt.mem_addr  = addr;
        end
      end
      REQ_MEM_WR: begin
        priority if (addr < CTRL_BASE) begin
          stage_nxt.to_memory = 1'b1;
          stage_nxt.mem_addr  = addr;
        end else if (in_wdog || in_sound) begin
          // watchdog and sound registers are taken and dropped
        end else if (in_spr) begin
          spr_ctl.wr_en = in_valid;
        end else if (addr <= LATCH_HI) begin
          if (addr == IRQ_EN_ADDR) begin
            latch_nxt.irq_enable = in_data.write_byte[0];
          end
          if (addr == SOUND_EN_ADDR) begin
            latch_nxt.sound_enable = in_data.write_byte[0];
          end
          if (addr == FLIP_ADDR) begin
            latch_nxt.screen_flip = in_data.write_byte[0];
          end
        end else begin
          stage_nxt.accepted = 1'b0;
        end
      end
      REQ_IO_RD: begin
        // io reads answer zero
      end
      REQ_IO_WR: begin
        if (in_data.bus_address[7:0] == IO_VECTOR_PORT) begin
          latch_nxt.irq_vector = in_data.write_byte;
        end
      end
      default: begin
      end
    endcase
  end

  // control latches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= '0;
    end else if (in_valid) begin
      latch_r <= latch_nxt;
    end
  end

  // decoded stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

[hdl/arcade_io_address_decoder.sv]
// ----------------------------------------------------------------------------
// arcade_io_address_decoder
// Memory-mapped I/O decoder: input ports, dip byte, sprite registers and
// control latches, with pass-through of other accesses to external memory.
// ----------------------------------------------------------------------------
// result: out_valid strobes once a taken start has passed the decoded stage register and the result register
// throughput: one bus access per cycle, set by the single decode stage and
//   the one-port sprite register file
// reset: synchronous, latches and sprite registers read as zero, dip settings
//   return to their defaults; busy is high while rst_n is low
// the result receiver cannot stall
module arcade_io_address_decoder
  import aiod_pkg::*;
#(
  parameter int unsigned SPRITE_REG_COUNT = SPRITE_REG_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   in_data,
  output logic                  out_valid,
  output out_t                  out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned IDX_W = $clog2(SPRITE_REG_COUNT);

  logic              in_valid;
  cfg_t              cfg_r;
  cfg_t              cfg_nxt;
  spr_ctl_t          spr_ctl;
  logic [IDX_W-1:0]  spr_idx;
  logic [DATA_W-1:0] spr_rd_data;
  stage_t            stage_r;
  logic              stage_valid_r;
  latch_t            latch_r;
  out_t              out_nxt;
  out_t              out_r;
  logic              out_valid_r;

  assign busy     = ~rst_n;
  assign in_valid = start & ~busy;

  // dip settings register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COIN:  cfg_nxt.coin_mode        = cfg_wdata;
        CFG_LIVES: cfg_nxt.lives_mode       = cfg_wdata;
        CFG_BONUS: cfg_nxt.bonus_mode       = cfg_wdata;
        CFG_DIFF:  cfg_nxt.difficulty_mode  = cfg_wdata[0];
        CFG_GHOST: cfg_nxt.ghost_name_mode  = cfg_wdata[0];
        CFG_RACK:  cfg_nxt.rack_advance_off = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coin_mode        <= 2'd1;
      cfg_r.lives_mode       <= 2'd2;
      cfg_r.bonus_mode       <= 2'd0;
      cfg_r.difficulty_mode  <= 1'b1;
      cfg_r.ghost_name_mode  <= 1'b1;
      cfg_r.rack_advance_off <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input stage
  aiod_decode #(
    .SPRITE_REG_COUNT(SPRITE_REG_COUNT)
  ) u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data      (in_data),
    .cfg          (cfg_r),
    .spr_ctl      (spr_ctl),
    .spr_idx      (spr_idx),
    .stage_r      (stage_r),
    .stage_valid_r(stage_valid_r),
    .latch_r      (latch_r)
  );

  // sprite coordinate registers
  aiod_sprite_mem #(
    .SPRITE_REG_COUNT(SPRITE_REG_COUNT)
  ) u_sprite_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (spr_ctl),
    .idx    (spr_idx),
    .rd_data(spr_rd_data)
  );

  // result assembly
  always_comb begin
    out_nxt.read_byte      = stage_r.use_sprite ? spr_rd_data : stage_r.rd_byte;
    out_nxt.to_memory      = stage_r.to_memory;
    out_nxt.memory_address = stage_r.mem_addr;
    out_nxt.accepted       = stage_r.accepted;
    out_nxt.irq_enable     = latch_r.irq_enable;
    out_nxt.sound_enable   = latch_r.sound_enable;
    out_nxt.screen_flip    = latch_r.screen_flip;
    out_nxt.irq_vector     = latch_r.irq_vector;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stage_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // every taken beat yields exactly one result, through the stage and result registers
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start && !busy, 2))
    else $error("result strobe does not follow accepted beat");

  // an access routed out is never served or rejected here
  a_route_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.to_memory) |->
      (out_data.read_byte == 8'h00 && out_data.accepted))
    else $error("routed access also served locally");

  // external address only shown for routed accesses
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.to_memory) |-> (out_data.memory_address == '0))
    else $error("memory address set on a local access");

  // a rejected write returns no data
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.accepted) |->
      (out_data.read_byte == 8'h00 && !out_data.to_memory))
    else $error("rejected access returned data");
`endif

endmodule
